// ===== hdl/imu_sa_pkg.sv =====
// imu_sa_pkg: constants, types and state codes shared by the imu still-alignment averager
// no dependencies; imported by every module of the block except imu_sa_checker
`default_nettype none

package imu_sa_pkg;

   // window and field geometry
   localparam int WINDOW_SAMPLES = 100;
   localparam int IDX_W          = $clog2(WINDOW_SAMPLES);
   localparam int SAMPLE_W       = 24;
   localparam int MEAN_W         = SAMPLE_W + 1;
   localparam int SUM_W          = 32;
   localparam int NOISE_W        = 31;
   localparam int COUNT_W        = 8;
   localparam int LOCK_W         = 8;
   localparam int CSR_DATA_W     = 31;
   localparam int CSR_IDX_W      = 1;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SAMPLES - 1);

   // lanes: gyro p q r, accel x y z, mag x y z
   localparam int NUM_LANES     = 9;
   localparam int NUM_IMU_LANES = 6;
   localparam int TAG_W         = 4;
   localparam logic [TAG_W-1:0] LANE_AZ  = TAG_W'(5);
   localparam logic [TAG_W-1:0] TAG_MEAN = TAG_W'(NUM_LANES);

   // divide by window length: reciprocal multiply plus one correction step
   localparam logic [SUM_W-1:0]   DIV_N       = SUM_W'(WINDOW_SAMPLES);
   localparam logic [SUM_W-1:0]   DIV_HALF    = SUM_W'(WINDOW_SAMPLES / 2);
   localparam logic [2*SUM_W-1:0] RECIP_FULL  = (64'd1 << SUM_W) / 64'(WINDOW_SAMPLES);
   localparam logic [SUM_W-1:0]   DIV_RECIP   = RECIP_FULL[SUM_W-1:0];

   // register reset values
   localparam logic [CSR_DATA_W-1:0] NOISE_THRESHOLD_RESET = CSR_DATA_W'(90000);
   localparam logic [LOCK_W-1:0]     LOCK_WINDOWS_RESET    = LOCK_W'(5);
   localparam logic [COUNT_W-1:0]    COUNT_MAX             = '1;

   typedef logic [SUM_W-1:0]    sum_type;
   typedef logic [SAMPLE_W-1:0] sample_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOISE_THRESHOLD = 1'b0,
      CSR_LOCK_WINDOWS    = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_DIV,
      ST_DIV_WAIT,
      ST_WALK,
      ST_TAIL,
      ST_DONE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic add_imu;
      logic add_mag;
      logic clear;
   } lane_ctl_type;

   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
      logic             round;
      logic [SUM_W-1:0] value;
   } div_req_type;

   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
      logic [SUM_W-1:0] quot;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== hdl/imu_sa_lane.sv =====
// imu_sa_lane: one axis accumulator lane, sign-extends a sample and adds it to a 32-bit sum
// depends on imu_sa_pkg
`default_nettype none

module imu_sa_lane
   import imu_sa_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       add,
   input  wire logic       clear,
   input  wire sample_type sample,
   output sum_type         sum
);

   sum_type sum_ff;
   sum_type sum_in;

   always_comb begin
      sum_in = sum_ff;
      if (clear) begin
         sum_in = '0;
      end else if (add) begin
         sum_in = sum_ff + {{(SUM_W - SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

`default_nettype wire

// ===== hdl/imu_sa_div.sv =====
// imu_sa_div: four-stage pipeline dividing a signed sum by the window length
// truncates toward zero, or rounds half away from zero when asked; depends on imu_sa_pkg
`default_nettype none

module imu_sa_div
   import imu_sa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   // stage 1: magnitude plus optional half
   logic             v1_ff, v2_ff, v3_ff, v4_ff;
   logic [TAG_W-1:0] tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic             neg1_ff, neg2_ff, neg3_ff;
   logic [SUM_W-1:0] x1_ff, x2_ff;
   logic [2*SUM_W-1:0] prod2_ff;
   logic [SUM_W-1:0] q3_ff, r3_ff, q4_ff;

   logic [SUM_W-1:0] mag_in;
   logic [SUM_W-1:0] x1_in;
   logic [SUM_W-1:0] q0;
   logic [SUM_W-1:0] r3_in;
   logic [SUM_W-1:0] qc;
   logic [SUM_W-1:0] q4_in;

   always_comb begin
      mag_in = req.value[SUM_W-1] ? (~req.value + SUM_W'(1)) : req.value;
      x1_in  = mag_in + (req.round ? DIV_HALF : '0);
      q0     = prod2_ff[2*SUM_W-1:SUM_W];
      r3_in  = x2_ff - SUM_W'(q0 * DIV_N);
      qc     = (r3_ff >= DIV_N) ? (q3_ff + SUM_W'(1)) : q3_ff;
      q4_in  = neg3_ff ? (~qc + SUM_W'(1)) : qc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff  <= req.tag;
      neg1_ff  <= req.value[SUM_W-1];
      x1_ff    <= x1_in;
      // stage 2: reciprocal multiply
      tag2_ff  <= tag1_ff;
      neg2_ff  <= neg1_ff;
      x2_ff    <= x1_ff;
      prod2_ff <= {{SUM_W{1'b0}}, x1_ff} * {{SUM_W{1'b0}}, DIV_RECIP};
      // stage 3: estimate and remainder
      tag3_ff  <= tag2_ff;
      neg3_ff  <= neg2_ff;
      q3_ff    <= q0;
      r3_ff    <= r3_in;
      // stage 4: correction and sign
      tag4_ff  <= tag3_ff;
      q4_ff    <= q4_in;
   end

   assign rsp.valid = v4_ff;
   assign rsp.tag   = tag4_ff;
   assign rsp.quot  = q4_ff;

endmodule

`default_nettype wire

// ===== hdl/imu_sa_merge.sv =====
// imu_sa_merge: window sequencer, z sample store, noise walk and quiet-window counter
// combines the lane sums at window end; depends on imu_sa_pkg and imu_sa_div
`default_nettype none

module imu_sa_merge
   import imu_sa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_restart,
   input  wire sample_type            req_accel_z,
   input  wire logic                  req_mag_present,
   input  wire logic [CSR_DATA_W-1:0] noise_threshold,
   input  wire logic [LOCK_W-1:0]     lock_windows,
   input  wire sum_type               lane_sum [NUM_LANES],
   output lane_ctl_type               lane_ctl,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output sample_type                 avg [NUM_LANES],
   output logic [NOISE_W-1:0]         noise,
   output logic [COUNT_W-1:0]         quiet_count,
   output logic                       locked
);

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     walk_ff, walk_in;
   logic [TAG_W-1:0]     issue_ff, issue_in;
   logic [NOISE_W-1:0]   noise_ff, noise_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic                 lock_ff, lock_in;
   logic                 rd_vld_ff, rd_vld_in;
   sample_type           rdata_ff;
   logic [MEAN_W-1:0]    mean_ff;
   sample_type           avg_ff [NUM_LANES];
   sample_type           zmem [WINDOW_SAMPLES];

   logic                 mem_we;
   logic [TAG_W-1:0]     lane_sel;
   logic signed [SAMPLE_W+1:0] dev;
   logic [SAMPLE_W+1:0]  dev_abs;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   imu_sa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // divider feed: nine truncated averages, then the rounded z mean
   always_comb begin
      lane_sel      = (issue_ff == TAG_MEAN) ? LANE_AZ : issue_ff;
      div_req.valid = (state_ff == ST_DIV);
      div_req.tag   = issue_ff;
      div_req.round = (issue_ff == TAG_MEAN);
      div_req.value = lane_sum[lane_sel];
   end

   // absolute deviation of a stored z from the rounded mean
   always_comb begin
      dev     = $signed({{2{rdata_ff[SAMPLE_W-1]}}, rdata_ff})
                - $signed({mean_ff[MEAN_W-1], mean_ff});
      dev_abs = dev[SAMPLE_W+1] ? (~dev + (SAMPLE_W+2)'(1)) : dev;
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      walk_in   = walk_ff;
      issue_in  = issue_ff;
      cnt_in    = cnt_ff;
      lock_in   = lock_ff;
      rd_vld_in = 1'b0;
      noise_in  = noise_ff;
      mem_we    = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      lane_ctl  = '0;

      if (rd_vld_ff) begin
         noise_in = noise_ff + NOISE_W'(dev_abs);
      end

      case (state_ff)
         ST_RUN: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_restart) begin
                  idx_in         = '0;
                  cnt_in         = '0;
                  lock_in        = 1'b0;
                  lane_ctl.clear = 1'b1;
               end else if (!lock_ff) begin
                  lane_ctl.add_imu = 1'b1;
                  lane_ctl.add_mag = req_mag_present;
                  mem_we           = 1'b1;
                  if (idx_ff == LAST_IDX) begin
                     idx_in   = '0;
                     issue_in = '0;
                     state_in = ST_DIV;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end
            end
         end
         ST_DIV: begin
            issue_in = issue_ff + TAG_W'(1);
            if (issue_ff == TAG_MEAN) begin
               state_in = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_rsp.valid && (div_rsp.tag == TAG_MEAN)) begin
               walk_in  = '0;
               noise_in = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            rd_vld_in = 1'b1;
            walk_in   = walk_ff + IDX_W'(1);
            if (walk_ff == LAST_IDX) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (noise_ff < noise_threshold) begin
               if (cnt_ff != COUNT_MAX) begin
                  cnt_in = cnt_ff + COUNT_W'(1);
               end
            end else if (cnt_ff != '0) begin
               cnt_in = cnt_ff - COUNT_W'(1);
            end
            lock_in        = (cnt_in > lock_windows);
            lane_ctl.clear = 1'b1;
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_RUN;
         idx_ff    <= '0;
         walk_ff   <= '0;
         issue_ff  <= '0;
         cnt_ff    <= '0;
         lock_ff   <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         walk_ff   <= walk_in;
         issue_ff  <= issue_in;
         cnt_ff    <= cnt_in;
         lock_ff   <= lock_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      noise_ff <= noise_in;
      if (div_rsp.valid) begin
         if (div_rsp.tag == TAG_MEAN) begin
            mean_ff <= div_rsp.quot[MEAN_W-1:0];
         end else begin
            avg_ff[div_rsp.tag] <= div_rsp.quot[SAMPLE_W-1:0];
         end
      end
   end

   // z sample store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         zmem[idx_ff] <= req_accel_z;
      end
      rdata_ff <= zmem[walk_ff];
   end

   assign avg         = avg_ff;
   assign noise       = noise_ff;
   assign quiet_count = cnt_ff;
   assign locked      = lock_ff;

endmodule

`default_nettype wire

// ===== hdl/imu_still_alignment_averager.sv =====
// imu_still_alignment_averager: top level of the still-alignment averager
// depends on imu_sa_pkg, imu_sa_lane and imu_sa_merge
`default_nettype none

// Sums each of the nine IMU axes over a window of WINDOW_SAMPLES samples in
// nine accumulator lanes and, at window end, returns one transaction with the
// per-axis averages (truncated toward zero), the accel z noise figure (sum of
// |z - rounded mean z|), the quiet-window count and the lock flag. A sample
// transaction is taken while running; mid-window samples and
// samples seen after lock give no result, and a restart transaction clears
// sums, window index, counter and lock without a result. The last sample of a
// window starts the end-of-window pass, during which req_ready is low: ten
// divisions through one four-stage reciprocal divider, then a walk of the z
// store at one entry per cycle, a counter update, then the result waits for
// rsp_ready. The user must write registers through the csr port only while
// the block is idle; the block itself does not enforce it.
module imu_still_alignment_averager
   import imu_sa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_restart,
   input  wire logic signed [23:0]    req_gyro_p,
   input  wire logic signed [23:0]    req_gyro_q,
   input  wire logic signed [23:0]    req_gyro_r,
   input  wire logic signed [23:0]    req_accel_x,
   input  wire logic signed [23:0]    req_accel_y,
   input  wire logic signed [23:0]    req_accel_z,
   input  wire logic signed [23:0]    req_mag_x,
   input  wire logic signed [23:0]    req_mag_y,
   input  wire logic signed [23:0]    req_mag_z,
   input  wire logic                  req_mag_present,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic signed [23:0]         rsp_avg_gyro_p,
   output logic signed [23:0]         rsp_avg_gyro_q,
   output logic signed [23:0]         rsp_avg_gyro_r,
   output logic signed [23:0]         rsp_avg_accel_x,
   output logic signed [23:0]         rsp_avg_accel_y,
   output logic signed [23:0]         rsp_avg_accel_z,
   output logic signed [23:0]         rsp_avg_mag_x,
   output logic signed [23:0]         rsp_avg_mag_y,
   output logic signed [23:0]         rsp_avg_mag_z,
   output logic [30:0]                rsp_noise_sum,
   output logic [7:0]                 rsp_quiet_count,
   output logic                       rsp_locked,

   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [CSR_DATA_W-1:0] noise_threshold_ff;
   logic [LOCK_W-1:0]     lock_windows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_threshold_ff <= NOISE_THRESHOLD_RESET;
         lock_windows_ff    <= LOCK_WINDOWS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_NOISE_THRESHOLD: begin
               noise_threshold_ff <= csr_wdata;
            end
            CSR_LOCK_WINDOWS: begin
               lock_windows_ff <= csr_wdata[LOCK_W-1:0];
            end
            default: begin
               noise_threshold_ff <= noise_threshold_ff;
            end
         endcase
      end
   end

   // lane inputs in lane order: gyro, accel, mag
   sample_type   lane_in  [NUM_LANES];
   sum_type      lane_sum [NUM_LANES];
   sample_type   avg      [NUM_LANES];
   lane_ctl_type lane_ctl;

   assign lane_in[0] = req_gyro_p;
   assign lane_in[1] = req_gyro_q;
   assign lane_in[2] = req_gyro_r;
   assign lane_in[3] = req_accel_x;
   assign lane_in[4] = req_accel_y;
   assign lane_in[5] = req_accel_z;
   assign lane_in[6] = req_mag_x;
   assign lane_in[7] = req_mag_y;
   assign lane_in[8] = req_mag_z;

   // mag lanes only add when the mag sample is flagged present
   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      imu_sa_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .add    ((i < NUM_IMU_LANES) ? lane_ctl.add_imu : lane_ctl.add_mag),
         .clear  (lane_ctl.clear),
         .sample (lane_in[i]),
         .sum    (lane_sum[i])
      );
   end

   // end-of-window merge: mean, noise walk, averages, counter and lock
   imu_sa_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .req_accel_z     (req_accel_z),
      .req_mag_present (req_mag_present),
      .noise_threshold (noise_threshold_ff),
      .lock_windows    (lock_windows_ff),
      .lane_sum        (lane_sum),
      .lane_ctl        (lane_ctl),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .avg             (avg),
      .noise           (rsp_noise_sum),
      .quiet_count     (rsp_quiet_count),
      .locked          (rsp_locked)
   );

   assign rsp_avg_gyro_p  = avg[0];
   assign rsp_avg_gyro_q  = avg[1];
   assign rsp_avg_gyro_r  = avg[2];
   assign rsp_avg_accel_x = avg[3];
   assign rsp_avg_accel_y = avg[4];
   assign rsp_avg_accel_z = avg[5];
   assign rsp_avg_mag_x   = avg[6];
   assign rsp_avg_mag_y   = avg[7];
   assign rsp_avg_mag_z   = avg[8];

endmodule

`default_nettype wire

// ===== hdl/imu_sa_checker.sv =====
// imu_sa_checker: port-level assertions for the still-alignment averager, plus its bind
// no package dependency; bound to imu_still_alignment_averager
`default_nettype none

module imu_sa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_restart,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [30:0] rsp_noise_sum,
   input wire logic [7:0]  rsp_quiet_count,
   input wire logic        rsp_locked
);

   // a pending result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_noise_sum))
      else $error("result dropped or changed while stalled");

   // no new sample while a window result is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while a result is pending");

   // lock needs at least one quiet window
   a_lock_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_locked |-> rsp_quiet_count != 8'd0)
      else $error("locked with zero quiet count");

   // a restart transaction never produces a result
   a_restart_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_restart |=> !rsp_valid)
      else $error("result after restart");

   // nothing is shown right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind imu_still_alignment_averager imu_sa_checker u_checker (.*);

`default_nettype wire
